>>> rtl/core/pkto_pkg.sv
// Shared types, constants and sine table functions for the piano key tone oscillator.
package pkto_pkg;

   localparam int unsigned PHASE_BITS_DEF  = 10;
   localparam int unsigned KEY_BITS        = 7;
   localparam int unsigned TIME_BITS       = 32;
   localparam int unsigned FUNC_BITS       = 3;
   localparam int unsigned SAMPLE_BITS     = 16;
   localparam int unsigned MAG_BITS        = 15;
   localparam int unsigned FREQ_BITS       = 32;
   localparam int unsigned OCT_BITS        = 3;
   localparam int unsigned FRAC_BITS       = 42;
   localparam int unsigned KEYS_PER_OCTAVE = 12;
   localparam int unsigned OCTAVES         = 8;

   localparam logic [KEY_BITS-1:0]           KEY_FIRST  = 7'd1;
   localparam logic [KEY_BITS-1:0]           KEY_LAST   = 7'd88;
   localparam logic signed [SAMPLE_BITS-1:0] FULL_SCALE = 16'sd16384;
   localparam logic [63:0]                   HALF_PI_Q61 = 64'h3243F6A8885A308D;
   localparam logic [63:0]                   ROUND_Q47   = 64'd1 << 46;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_SINE        = 3'd0,
      FUNC_SQUARE      = 3'd1,
      FUNC_TRIANGLE    = 3'd2,
      FUNC_ANALOG_SAW  = 3'd3,
      FUNC_DIGITAL_SAW = 3'd4,
      FUNC_NOISE       = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      WAVE_ZERO,
      WAVE_SINE,
      WAVE_SQUARE,
      WAVE_SAW
   } wave_type;

   // Decoded request: base frequency, octave shift, waveform and time.
   typedef struct packed {
      logic [FREQ_BITS-1:0] freq;
      logic [OCT_BITS-1:0]  oct;
      wave_type             wave;
      logic [TIME_BITS-1:0] time_q16;
   } dec_type;

   // Product stage: low fractional bits of freq * time.
   typedef struct packed {
      logic [FRAC_BITS-1:0] prod;
      logic [OCT_BITS-1:0]  oct;
      wave_type             wave;
   } prod_type;

   // A0..Ab1 in Q6.26, rounded to nearest.
   function automatic logic [FREQ_BITS-1:0] base_freq(input logic [3:0] idx);
      logic [FREQ_BITS-1:0] f;
      begin
         case (idx)
            4'd0:    f = 32'd1845493760;
            4'd1:    f = 32'd1955236885;
            4'd2:    f = 32'd2071496281;
            4'd3:    f = 32'd2194674601;
            4'd4:    f = 32'd2325181209;
            4'd5:    f = 32'd2463438891;
            4'd6:    f = 32'd2609924119;
            4'd7:    f = 32'd2765120078;
            4'd8:    f = 32'd2929543506;
            4'd9:    f = 32'd3103737984;
            4'd10:   f = 32'd3288300782;
            4'd11:   f = 32'd3483822457;
            default: f = '0;
         endcase
         return f;
      end
   endfunction

   // (a * b) >> 61 with the full 128-bit product, Q2.61 arithmetic.
   function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      begin
         p = {64'd0, a} * {64'd0, b};
         return p[124:61];
      end
   endfunction

   // Taylor series of sin on a quarter wave, Q2.61 in and out.
   function automatic logic [63:0] sin_q61(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      begin
         x2   = mul_q61(x, x);
         term = x;
         sum  = x;
         term = mul_q61(term, x2) / 64'd6;   sum = sum - term;
         term = mul_q61(term, x2) / 64'd20;  sum = sum + term;
         term = mul_q61(term, x2) / 64'd42;  sum = sum - term;
         term = mul_q61(term, x2) / 64'd72;  sum = sum + term;
         term = mul_q61(term, x2) / 64'd110; sum = sum - term;
         term = mul_q61(term, x2) / 64'd156; sum = sum + term;
         term = mul_q61(term, x2) / 64'd210; sum = sum - term;
         term = mul_q61(term, x2) / 64'd272; sum = sum + term;
         term = mul_q61(term, x2) / 64'd342; sum = sum - term;
         term = mul_q61(term, x2) / 64'd420; sum = sum + term;
         term = mul_q61(term, x2) / 64'd506; sum = sum - term;
         term = mul_q61(term, x2) / 64'd600; sum = sum + term;
         return sum;
      end
   endfunction

   // Rounded 16384 * sin(pi/2 * a / 2^qbits); evaluated at elaboration only.
   function automatic logic [MAG_BITS-1:0] sine_mag(input int unsigned a,
                                                    input int unsigned qbits);
      logic [127:0] ax;
      logic [63:0]  x;
      logic [63:0]  s;
      logic [63:0]  m;
      begin
         ax = {96'd0, a} * {64'd0, HALF_PI_Q61};
         ax = ax >> qbits;
         x  = ax[63:0];
         s  = sin_q61(x);
         m  = (s + ROUND_Q47) >> 47;
         return m[MAG_BITS-1:0];
      end
   endfunction

endpackage

>>> rtl/core/pkto_key_decode.sv
// Key decode: octave and note from the key number, base frequency and waveform select.
module pkto_key_decode (
   input  logic [pkto_pkg::KEY_BITS-1:0]  key_number,
   input  logic [pkto_pkg::TIME_BITS-1:0] time_q16,
   input  logic [pkto_pkg::FUNC_BITS-1:0] func,
   output pkto_pkg::dec_type              dec
);

   logic [pkto_pkg::KEY_BITS-1:0] key_m1;
   logic [pkto_pkg::KEY_BITS-1:0] note;
   logic [pkto_pkg::OCT_BITS-1:0] oct;
   logic                          key_ok;
   pkto_pkg::wave_type            wave;

   always_comb begin
      key_m1 = key_number - 7'd1;
      key_ok = (key_number >= pkto_pkg::KEY_FIRST) && (key_number <= pkto_pkg::KEY_LAST);
      oct    = '0;
      // Thresholds rise monotonically, so the last match is the octave.
      for (int k = 1; k < pkto_pkg::OCTAVES; k++) begin
         if (key_m1 >= 7'(k * pkto_pkg::KEYS_PER_OCTAVE)) begin
            oct = 3'(k);
         end
      end
      note = key_m1 - (7'({oct, 3'b000}) + 7'({oct, 2'b00}));
   end

   always_comb begin
      case (func)
         pkto_pkg::FUNC_SINE:        wave = pkto_pkg::WAVE_SINE;
         pkto_pkg::FUNC_SQUARE:      wave = pkto_pkg::WAVE_SQUARE;
         pkto_pkg::FUNC_DIGITAL_SAW: wave = pkto_pkg::WAVE_SAW;
         pkto_pkg::FUNC_TRIANGLE,
         pkto_pkg::FUNC_ANALOG_SAW,
         pkto_pkg::FUNC_NOISE:       wave = pkto_pkg::WAVE_ZERO;
         default:                    wave = pkto_pkg::WAVE_ZERO;
      endcase
      // Out-of-range keys give silence.
      if (!key_ok) begin
         wave = pkto_pkg::WAVE_ZERO;
      end
   end

   assign dec.freq     = pkto_pkg::base_freq(note[3:0]);
   assign dec.oct      = oct;
   assign dec.wave     = wave;
   assign dec.time_q16 = time_q16;

endmodule

>>> rtl/core/pkto_phase_unit.sv
// Phase extraction: octave shift of the product, quarter-wave fold and saw value.
module pkto_phase_unit #(
   parameter int unsigned PHASE_BITS = pkto_pkg::PHASE_BITS_DEF
) (
   input  logic [pkto_pkg::FRAC_BITS-1:0]          prod,
   input  logic [pkto_pkg::OCT_BITS-1:0]           oct,
   output logic [PHASE_BITS-2:0]                   addr,
   output logic [1:0]                              quad,
   output logic signed [pkto_pkg::SAMPLE_BITS-1:0] saw
);

   localparam logic [PHASE_BITS-2:0] QUARTER = (PHASE_BITS-1)'(1) << (PHASE_BITS - 2);

   logic [pkto_pkg::FRAC_BITS-1:0] prod_sh;
   logic [PHASE_BITS-1:0]          phase;
   logic [PHASE_BITS-2:0]          rem;
   logic [PHASE_BITS+14:0]         scaled;

   always_comb begin
      // Shift by octave and keep only the fractional bits.
      prod_sh = prod << oct;
      phase   = prod_sh[pkto_pkg::FRAC_BITS-1 -: PHASE_BITS];
      quad    = phase[PHASE_BITS-1 -: 2];
      rem     = {1'b0, phase[PHASE_BITS-3:0]};
      // Mirror odd quadrants back onto the rising quarter.
      addr    = quad[0] ? (QUARTER - rem) : rem;
      scaled  = {phase, 15'd0} >> PHASE_BITS;
      saw     = $signed({1'b0, scaled[14:0]}) - pkto_pkg::FULL_SCALE;
   end

endmodule

>>> rtl/core/pkto_sine_rom.sv
// Quarter-wave sine magnitude table with registered read.
module pkto_sine_rom #(
   parameter int unsigned ADDR_BITS = pkto_pkg::PHASE_BITS_DEF - 1
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [ADDR_BITS-1:0]          addr,
   output logic [pkto_pkg::MAG_BITS-1:0] data_ff
);

   localparam int unsigned DEPTH   = 1 << ADDR_BITS;
   localparam int unsigned QUARTER = 1 << (ADDR_BITS - 1);

   logic [pkto_pkg::MAG_BITS-1:0] sine_rom [DEPTH];
   logic [pkto_pkg::MAG_BITS-1:0] data_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      if (i <= QUARTER) begin : g_used
         assign sine_rom[i] = pkto_pkg::sine_mag(i, ADDR_BITS - 1);
      end else begin : g_spare
         assign sine_rom[i] = '0;
      end
   end

   assign data_in = sine_rom[addr];

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/core/piano_key_tone_oscillator.sv
// Piano key tone oscillator: top level with the five-stage request pipeline.
// Throughput: one request per cycle while the output is not stalled; stages are decode,
// 32x32 multiply, phase fold, sine table read and output select, each a register stage
// with its own valid bit. A stall holds each full stage with no empty stage between it
// and the output; empty stages still fill, so no request is lost.
// Reset clears all valid bits; the sine table is constant and needs no fill.
module piano_key_tone_oscillator #(
   parameter int unsigned PHASE_BITS = pkto_pkg::PHASE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [pkto_pkg::KEY_BITS-1:0]           req_key_number,
   input  logic [pkto_pkg::TIME_BITS-1:0]          req_time_q16,
   input  logic [pkto_pkg::FUNC_BITS-1:0]          req_func,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pkto_pkg::SAMPLE_BITS-1:0] rsp_sample_out
);

   localparam int unsigned SB = pkto_pkg::SAMPLE_BITS;

   // Stage control.
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // Stage payloads.
   pkto_pkg::dec_type  s1_in, s1_ff;
   pkto_pkg::prod_type s2_in, s2_ff;
   logic [63:0]        mult_full;

   logic [PHASE_BITS-2:0]  s3_addr_in, s3_addr_ff;
   logic [1:0]             s3_quad_in, s3_quad_ff;
   logic signed [SB-1:0]   s3_saw_in, s3_saw_ff;
   pkto_pkg::wave_type     s3_wave_ff;

   logic [pkto_pkg::MAG_BITS-1:0] s4_mag_ff;
   logic [1:0]                    s4_quad_ff;
   logic signed [SB-1:0]          s4_saw_ff;
   pkto_pkg::wave_type            s4_wave_ff;

   logic signed [SB-1:0] mag_ext;
   logic signed [SB-1:0] rsp_sample_in, rsp_sample_ff;

   assign rdy5      = !rsp_valid_ff || rsp_ready;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff        <= req_valid;
         if (rdy2) v2_ff        <= v1_ff;
         if (rdy3) v3_ff        <= v2_ff;
         if (rdy4) v4_ff        <= v3_ff;
         if (rdy5) rsp_valid_ff <= v4_ff;
      end
   end

   // Stage 1: decode the key.
   pkto_key_decode u_key_decode (
      .key_number (req_key_number),
      .time_q16   (req_time_q16),
      .func       (req_func),
      .dec        (s1_in)
   );

   // Stage 2: multiply; only the fractional bits matter.
   assign mult_full  = {32'd0, s1_ff.freq} * {32'd0, s1_ff.time_q16};
   assign s2_in.prod = mult_full[pkto_pkg::FRAC_BITS-1:0];
   assign s2_in.oct  = s1_ff.oct;
   assign s2_in.wave = s1_ff.wave;

   // Stage 3: phase and fold.
   pkto_phase_unit #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase_unit (
      .prod (s2_ff.prod),
      .oct  (s2_ff.oct),
      .addr (s3_addr_in),
      .quad (s3_quad_in),
      .saw  (s3_saw_in)
   );

   // Stage 4: table read.
   pkto_sine_rom #(
      .ADDR_BITS (PHASE_BITS - 1)
   ) u_sine_rom (
      .clock   (clock),
      .enable  (rdy4),
      .addr    (s3_addr_ff),
      .data_ff (s4_mag_ff)
   );

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
      if (rdy3) begin
         s3_addr_ff <= s3_addr_in;
         s3_quad_ff <= s3_quad_in;
         s3_saw_ff  <= s3_saw_in;
         s3_wave_ff <= s2_ff.wave;
      end
      if (rdy4) begin
         s4_quad_ff <= s3_quad_ff;
         s4_saw_ff  <= s3_saw_ff;
         s4_wave_ff <= s3_wave_ff;
      end
      if (rdy5) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   // Stage 5: sign the sine and select the waveform.
   always_comb begin
      mag_ext = $signed({1'b0, s4_mag_ff});
      case (s4_wave_ff)
         pkto_pkg::WAVE_SINE: begin
            rsp_sample_in = s4_quad_ff[1] ? -mag_ext : mag_ext;
         end
         pkto_pkg::WAVE_SQUARE: begin
            // High only where the rounded sine is strictly positive.
            rsp_sample_in = (!s4_quad_ff[1] && (s4_mag_ff != '0)) ?
                            pkto_pkg::FULL_SCALE : -pkto_pkg::FULL_SCALE;
         end
         pkto_pkg::WAVE_SAW: begin
            rsp_sample_in = s4_saw_ff;
         end
         default: begin
            rsp_sample_in = '0;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

`ifndef ASSERT_OFF
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted request did not enter the first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !rdy5) |=> v4_ff)
      else $error("table stage dropped a request under stall");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_out <= pkto_pkg::FULL_SCALE) &&
                    (rsp_sample_out >= -pkto_pkg::FULL_SCALE))
      else $error("sample out of full-scale range");

   a_square_rails: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rdy5 && (s4_wave_ff == pkto_pkg::WAVE_SQUARE)) |=>
      ((rsp_sample_out == pkto_pkg::FULL_SCALE) ||
       (rsp_sample_out == -pkto_pkg::FULL_SCALE)))
      else $error("square sample not at a rail");

   a_silent: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rdy5 && (s4_wave_ff == pkto_pkg::WAVE_ZERO)) |=> (rsp_sample_out == '0))
      else $error("silent waveform gave a non-zero sample");
`endif

endmodule

>>> tb/tb_piano_key_tone_oscillator.sv
// Self-checking testbench for the piano key tone oscillator: directed table, then random notes.
module tb_piano_key_tone_oscillator;
   import pkto_pkg::*;

   localparam int unsigned PHASE_W      = PHASE_BITS_DEF;
   localparam int          DIR_ROWS     = 25;
   localparam int          RANDOM_ITEMS = 800;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          PRINT_LIMIT  = 40;

   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED6 = 3'd6;
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED7 = 3'd7;
   localparam logic [63:0] QUARTER_TURN_Q61 = 64'h3243F6A8885A308D;

   // A0..Ab1 in Q6.26, one octave of equal temperament.
   localparam logic [31:0] KEY_BASE_Q26 [12] = '{
      32'd1845493760, 32'd1955236885, 32'd2071496281, 32'd2194674601,
      32'd2325181209, 32'd2463438891, 32'd2609924119, 32'd2765120078,
      32'd2929543506, 32'd3103737984, 32'd3288300782, 32'd3483822457
   };

   typedef struct packed {
      logic [KEY_BITS-1:0]           key;
      logic [TIME_BITS-1:0]          t;
      logic [FUNC_BITS-1:0]          func;
      logic                          known;
      logic signed [SAMPLE_BITS-1:0] value;
   } tone_row_t;

   typedef struct {
      logic [KEY_BITS-1:0]           key;
      logic [TIME_BITS-1:0]          t;
      logic [FUNC_BITS-1:0]          func;
      logic signed [SAMPLE_BITS-1:0] sample;
   } tone_expect_t;

   // Typed values only where the waveform is plainly zero or at full scale.
   tone_row_t directed_rows [DIR_ROWS] = '{
      '{7'd0,   32'h1234_5678, FUNC_SINE,        1'b1, 16'sd0},
      '{7'd89,  32'hFFFF_FFFF, FUNC_SQUARE,      1'b1, 16'sd0},
      '{7'd127, 32'h8000_0000, FUNC_DIGITAL_SAW, 1'b1, 16'sd0},
      '{7'd0,   32'h0000_0000, FUNC_UNUSED7,     1'b1, 16'sd0},
      '{7'd1,   32'h0000_0000, FUNC_SINE,        1'b1, 16'sd0},
      '{7'd1,   32'h0000_0000, FUNC_SQUARE,      1'b1, -16'sd16384},
      '{7'd1,   32'h0000_0000, FUNC_DIGITAL_SAW, 1'b1, -16'sd16384},
      '{7'd1,   32'd596,       FUNC_SINE,        1'b1, 16'sd16384},
      '{7'd1,   32'd596,       FUNC_SQUARE,      1'b1, 16'sd16384},
      '{7'd1,   32'd1192,      FUNC_SQUARE,      1'b1, -16'sd16384},
      '{7'd1,   32'd1788,      FUNC_SINE,        1'b1, -16'sd16384},
      '{7'd49,  32'h0000_0100, FUNC_TRIANGLE,    1'b1, 16'sd0},
      '{7'd49,  32'h0000_0100, FUNC_ANALOG_SAW,  1'b1, 16'sd0},
      '{7'd49,  32'h0000_0100, FUNC_NOISE,       1'b1, 16'sd0},
      '{7'd49,  32'h0000_0100, FUNC_UNUSED6,     1'b1, 16'sd0},
      '{7'd49,  32'hFFFF_FFFF, FUNC_UNUSED7,     1'b1, 16'sd0},
      '{7'd88,  32'hFFFF_FFFF, FUNC_SINE,        1'b0, 16'sd0},
      '{7'd88,  32'hFFFF_FFFF, FUNC_SQUARE,      1'b0, 16'sd0},
      '{7'd88,  32'hFFFF_FFFF, FUNC_DIGITAL_SAW, 1'b0, 16'sd0},
      '{7'd1,   32'h0001_0000, FUNC_SINE,        1'b0, 16'sd0},
      '{7'd40,  32'h0000_A5A5, FUNC_SINE,        1'b0, 16'sd0},
      '{7'd12,  32'h7FFF_FFFF, FUNC_SQUARE,      1'b0, 16'sd0},
      '{7'd13,  32'h0000_0001, FUNC_DIGITAL_SAW, 1'b0, 16'sd0},
      '{7'd64,  32'hDEAD_BEEF, FUNC_SINE,        1'b0, 16'sd0},
      '{7'd88,  32'h0000_0001, FUNC_SINE,        1'b0, 16'sd0}
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid;
   logic                          req_ready;
   logic [KEY_BITS-1:0]           req_key_number;
   logic [TIME_BITS-1:0]          req_time_q16;
   logic [FUNC_BITS-1:0]          req_func;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;

   // Typed value travelling alongside the request, used in place of the predictor.
   logic                          fixed_known;
   logic signed [SAMPLE_BITS-1:0] fixed_value;

   tone_expect_t pending_samples [$];
   int           error_count = 0;
   int           cycle_count = 0;
   logic         calm = 1'b0;

   piano_key_tone_oscillator #(
      .PHASE_BITS(PHASE_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_number (req_key_number),
      .req_time_q16   (req_time_q16),
      .req_func       (req_func),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> sh;
      return p[63:0];
   endfunction

   // Taylor series over the first quarter wave, Q2.61 in and out.
   function automatic logic [63:0] quarter_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] divisor;
      int          n;
      x2  = mul_shift(x, x, 61);
      term = x;
      acc  = x;
      for (n = 1; n <= 12; n++) begin
         divisor = 64'(2 * n) * 64'(2 * n + 1);
         term    = mul_shift(term, x2, 61) / divisor;
         if (n % 2 == 1) acc = acc - term;
         else            acc = acc + term;
      end
      return acc;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sine_level(input logic [PHASE_W-1:0] ph);
      logic [1:0]  quad;
      logic [63:0] angle;
      logic [63:0] s;
      logic [63:0] m;
      int          mag;
      quad  = ph[PHASE_W-1 -: 2];
      angle = 64'(ph[PHASE_W-3:0]);
      // Fold the odd quadrants back onto the rising quarter.
      if (quad[0]) angle = (64'd1 << (PHASE_W - 2)) - angle;
      s   = quarter_sine(mul_shift(angle, QUARTER_TURN_Q61, PHASE_W - 2));
      m   = (s + (64'd1 << 46)) >> 47;
      mag = int'(m[15:0]);
      return quad[1] ? 16'(-mag) : 16'(mag);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] tone_sample(
      input logic [KEY_BITS-1:0] key, input logic [TIME_BITS-1:0] t,
      input logic [FUNC_BITS-1:0] func);
      logic [63:0]       freq;
      logic [63:0]       prod;
      logic [63:0]       ramp;
      logic [PHASE_W-1:0] ph;
      int                note;
      if (key < KEY_FIRST || key > KEY_LAST) return '0;
      note = int'(key) - 1;
      freq = 64'(KEY_BASE_Q26[note % KEYS_PER_OCTAVE]) << (note / KEYS_PER_OCTAVE);
      prod = freq * {32'd0, t};
      ph   = prod[FRAC_BITS-1 -: PHASE_W];
      case (func)
         FUNC_SINE:   return sine_level(ph);
         FUNC_SQUARE: return (sine_level(ph) > 0) ? FULL_SCALE : -FULL_SCALE;
         FUNC_DIGITAL_SAW: begin
            ramp = (64'(ph) << 15) >> PHASE_W;
            return 16'(int'(ramp) - 16384);
         end
         default:     return '0;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [FUNC_BITS-1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return FUNC_SINE;
      if (r < 55) return FUNC_SQUARE;
      if (r < 80) return FUNC_DIGITAL_SAW;
      return FUNC_BITS'($urandom_range(0, 7));
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic [KEY_BITS-1:0] key, input logic [TIME_BITS-1:0] t,
                               input logic [FUNC_BITS-1:0] func, input logic known,
                               input logic signed [SAMPLE_BITS-1:0] value);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_key_number <= key;
      req_time_q16   <= t;
      req_func       <= func;
      fixed_known    <= known;
      fixed_value    <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : scoreboard
      tone_expect_t head;
      if (!reset) begin
         if (req_valid && req_ready) begin
            head.key    = req_key_number;
            head.t      = req_time_q16;
            head.func   = req_func;
            head.sample = fixed_known ? fixed_value
                                      : tone_sample(req_key_number, req_time_q16, req_func);
            pending_samples.push_back(head);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_samples.size() == 0) begin
               report_mismatch($sformatf("sample %0d with no request pending", rsp_sample_out));
            end else begin
               head = pending_samples.pop_front();
               if (rsp_sample_out !== head.sample)
                  report_mismatch($sformatf("key %0d time %h func %0d: sample %0d, want %0d",
                                            head.key, head.t, head.func,
                                            rsp_sample_out, head.sample));
            end
         end
      end
   end

   // Receiver: bursts of ready with stalls between, some long stretches without any.
   initial begin : receiver
      int run;
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         run = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("piano_key_tone_oscillator verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [KEY_BITS-1:0]  key;
      logic [TIME_BITS-1:0] t;
      logic [TIME_BITS-1:0] step;
      logic [FUNC_BITS-1:0] func;
      int                   len;
      int                   sent;
      req_valid      = 1'b0;
      req_key_number = '0;
      req_time_q16   = '0;
      req_func       = '0;
      fixed_known    = 1'b0;
      fixed_value    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].key, directed_rows[i].t, directed_rows[i].func,
                      directed_rows[i].known, directed_rows[i].value);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 99) < 20);
         if ($urandom_range(0, 99) < 70) begin
            // A held note: one key and waveform, time advancing steadily.
            key  = KEY_BITS'($urandom_range(1, 88));
            func = pick_func();
            t    = $urandom;
            step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                               : $urandom_range(1, 65535);
            len  = $urandom_range(8, 32);
            repeat (len) begin
               send_request(key, t, func, 1'b0, '0);
               t = t + step;
               sent++;
            end
         end else begin
            key = ($urandom_range(0, 99) < 80) ? KEY_BITS'($urandom_range(1, 88))
                                               : KEY_BITS'($urandom_range(0, 127));
            t   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom;
            send_request(key, t, FUNC_BITS'($urandom_range(0, 7)), 1'b0, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("piano_key_tone_oscillator verification clean");
      else
         $display("piano_key_tone_oscillator verification failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/pkto_pkg.sv
rtl/core/pkto_key_decode.sv
rtl/core/pkto_phase_unit.sv
rtl/core/pkto_sine_rom.sv
rtl/core/piano_key_tone_oscillator.sv
tb/tb_piano_key_tone_oscillator.sv
